// ===== src/swal_pkg.sv =====
// ----------------------------------------------------------------------------
// swal_pkg
// Shared types and constants for the sliding-window admission limiter.
// ----------------------------------------------------------------------------
package swal_pkg;

    // Width of a timestamp and of the tick clock.
    localparam int TS_W = 32;

    // Command codes.
    localparam logic [2:0] CMD_TICK      = 3'd0;
    localparam logic [2:0] CMD_CHECK_MSG = 3'd1;
    localparam logic [2:0] CMD_RECORD    = 3'd2;
    localparam logic [2:0] CMD_CHECK_ST  = 3'd3;
    localparam logic [2:0] CMD_START     = 3'd4;
    localparam logic [2:0] CMD_END       = 3'd5;
    localparam logic [2:0] CMD_PURGE     = 3'd6;
    localparam logic [2:0] CMD_UNUSED    = 3'd7;

    // Configuration register indexes.
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_WINDOW    = 3'd1;
    localparam logic [2:0] REG_MAX_MSGS  = 3'd2;
    localparam logic [2:0] REG_MAX_HIST  = 3'd3;
    localparam logic [2:0] REG_MAX_LINE  = 3'd4;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_EXPIRE = 4'b0100,
        S_SCAN   = 4'b1000
    } t_state;

    // Controls shared by every cell of the message ring.
    typedef struct packed {
        logic            shift;
        logic [TS_W-1:0] now;
        logic [15:0]     window;
    } t_msg_ctl;

    // Controls shared by every cell of one ID table.
    typedef struct packed {
        logic [TS_W-1:0] id;
        logic [TS_W-1:0] now;
        logic [30:0]     max_age;
        logic            set_new;
        logic            refresh;
        logic            clear_match;
        logic            purge;
    } t_tbl_ctl;

    // Population count of one byte.
    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'd0, v[k]};
        end
        return n;
    endfunction

endpackage

// ===== src/swal_msg_cell.sv =====
// ----------------------------------------------------------------------------
// swal_msg_cell
// One slot of the message timestamp ring; shifts towards the head on a pop.
// ----------------------------------------------------------------------------
module swal_msg_cell (
    input  logic               i_clk,
    input  swal_pkg::t_msg_ctl i_ctl,
    input  logic               i_wr,
    input  logic [31:0]        i_upper,
    output logic [31:0]        o_stamp,
    output logic               o_in_win
);
    import swal_pkg::*;

    logic [TS_W-1:0] r_stamp;
    logic [TS_W-1:0] n_stamp;
    logic [TS_W-1:0] age;

    // Take the neighbour's stamp on a shift, or the clock on a write.
    always_comb begin
        n_stamp = r_stamp;
        if (i_ctl.shift) begin
            n_stamp = i_upper;
        end else if (i_wr) begin
            n_stamp = i_ctl.now;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

    // Age test against the window, modulo the clock width.
    assign age      = i_ctl.now - r_stamp;
    assign o_in_win = (age <= {16'd0, i_ctl.window});
    assign o_stamp  = r_stamp;

endmodule

// ===== src/swal_tbl_cell.sv =====
// ----------------------------------------------------------------------------
// swal_tbl_cell
// One entry of an active ID table with its start time and valid bit.
// ----------------------------------------------------------------------------
module swal_tbl_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  swal_pkg::t_tbl_ctl i_ctl,
    input  logic               i_claim,
    output logic               o_claim,
    output logic               o_valid,
    output logic               o_match
);
    import swal_pkg::*;

    logic            r_valid;
    logic            n_valid;
    logic [TS_W-1:0] r_id;
    logic [TS_W-1:0] r_start;
    logic [TS_W-1:0] age;
    logic            aged;
    logic            take_new;

    assign o_match  = r_valid && (r_id == i_ctl.id);
    assign age      = i_ctl.now - r_start;
    assign aged     = r_valid && (age > {1'b0, i_ctl.max_age});

    // The lowest free cell not claimed further down takes a new entry.
    assign take_new = i_ctl.set_new && !r_valid && !i_claim;
    assign o_claim  = i_claim || !r_valid;

    always_comb begin
        n_valid = r_valid;
        if (take_new) begin
            n_valid = 1'b1;
        end else if (i_ctl.clear_match && o_match) begin
            n_valid = 1'b0;
        end else if (i_ctl.purge && aged) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Entry payload: new entry, or a refreshed start time for a known ID.
    always_ff @(posedge i_clk) begin
        if (take_new) begin
            r_id    <= i_ctl.id;
            r_start <= i_ctl.now;
        end else if (i_ctl.refresh && o_match) begin
            r_start <= i_ctl.now;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== src/sliding_window_admission_limiter_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_admission_limiter_top
// Message rate window and two active ID tables behind a command interface.
// ----------------------------------------------------------------------------
// Usage: raise start with a command and its operands while busy is low; the
// transaction is taken at that edge and busy stays high until it completes.
// One result per command appears on the o_ result ports for a single cycle,
// marked by o_result_valid, in the first cycle with busy low again; the
// receiver cannot stall, so it must sample the result in that cycle.
// Configuration registers are written through i_cfg_valid / o_cfg_ready
// (always ready); the user must write them only while the block is idle,
// which the block itself does not enforce.
// Sequence per command: S_EXEC applies it, then S_SCAN counts the ring and
// table cells byte by byte, then the result cycle follows. Check-message,
// and record-message when the ring then holds more than twice max_messages,
// pass through S_EXPIRE before the scan when enabled; it pops expired
// messages from the ring head until the head is in the window or the ring
// is empty. The next command can be taken at the earliest at the edge that
// ends the result cycle.
// Reset (synchronous, active low) clears the clock, the ring fill count and
// all table valid bits, and loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_admission_limiter_top #(
    parameter int MSG_DEPTH   = 128,
    parameter int TABLE_DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [2:0]                           i_command,
    input  logic                                 i_table_select,
    input  logic signed [31:0]                   i_req_tag,
    input  logic [15:0]                          i_elapsed_ticks,
    input  logic [30:0]                          i_max_age_ticks,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [2:0]                           i_cfg_index,
    input  logic [15:0]                          i_cfg_data,
    output logic                                 o_result_valid,
    output logic                                 o_allowed,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_active_hist,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]     o_active_lines,
    output logic [7:0]                           o_msgs_in_window,
    output logic                                 o_rate_limited,
    output logic                                 o_overflow
);
    import swal_pkg::*;

    localparam int MCW   = $clog2(MSG_DEPTH + 1);
    localparam int TCW   = $clog2(TABLE_DEPTH + 1);
    localparam int MCH   = (MSG_DEPTH + 7) / 8;
    localparam int TCH   = (TABLE_DEPTH + 7) / 8;
    localparam int NCH   = (MCH > TCH) ? MCH : TCH;
    localparam int SIW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int MWW   = (MCW > 8) ? MCW : 8;
    localparam int CMPW  = (TCW > 7) ? TCW : 7;

    // Configuration registers.
    logic        r_enable;
    logic [15:0] r_window;
    logic [5:0]  r_max_msgs;
    logic [6:0]  r_max_hist;
    logic [6:0]  r_max_line;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b1;
            r_window   <= 16'd1000;
            r_max_msgs <= 6'd50;
            r_max_hist <= 7'd50;
            r_max_line <= 7'd64;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_ENABLE:   r_enable   <= i_cfg_data[0];
                REG_WINDOW:   r_window   <= i_cfg_data;
                REG_MAX_MSGS: r_max_msgs <= i_cfg_data[5:0];
                REG_MAX_HIST: r_max_hist <= i_cfg_data[6:0];
                REG_MAX_LINE: r_max_line <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and command registers.
    t_state          r_state;
    logic [2:0]      r_cmd;
    logic            r_sel;
    logic [31:0]     r_id;
    logic [15:0]     r_elapsed;
    logic [30:0]     r_max_age;
    logic [TS_W-1:0] r_clock;
    logic [MCW-1:0]  r_msg_count;
    logic            r_allowed;
    logic            r_chk_msg;
    logic            r_ovf;
    logic [SIW-1:0]  r_scan;
    logic [MCW-1:0]  r_win_acc;
    logic [TCW-1:0]  r_hist_acc;
    logic [TCW-1:0]  r_line_acc;
    logic [TCW-1:0]  r_hist_cnt;
    logic [TCW-1:0]  r_line_cnt;

    assign busy = (r_state != S_IDLE);

    // Message ring: a row of cells, cell 0 holds the oldest stamp.
    t_msg_ctl        msg_ctl;
    logic [31:0]     msg_stamp [MSG_DEPTH];
    logic [MSG_DEPTH-1:0] msg_in_win;
    logic [MSG_DEPTH-1:0] msg_wr;
    logic [MSG_DEPTH-1:0] msg_cnt_win;
    logic            exec_record;
    logic            ring_full;
    logic            head_expired;

    assign exec_record  = (r_state == S_EXEC) && (r_cmd == CMD_RECORD) && r_enable;
    assign ring_full    = (r_msg_count == MCW'(MSG_DEPTH));
    assign head_expired = (r_msg_count != '0) && !msg_in_win[0];

    always_comb begin
        msg_ctl.now    = r_clock;
        msg_ctl.window = r_window;
        msg_ctl.shift  = (exec_record && ring_full) ||
                         ((r_state == S_EXPIRE) && head_expired);
    end

    for (genvar i = 0; i < MSG_DEPTH; i++) begin : g_msg
        logic [31:0] upper;
        if (i == MSG_DEPTH - 1) begin : g_top
            assign upper = r_clock;
        end else begin : g_mid
            assign upper = msg_stamp[i+1];
        end
        assign msg_wr[i]      = exec_record && !ring_full && (r_msg_count == MCW'(i));
        assign msg_cnt_win[i] = msg_in_win[i] && (MCW'(i) < r_msg_count);

        swal_msg_cell u_cell (
            .i_clk    (i_clk),
            .i_ctl    (msg_ctl),
            .i_wr     (msg_wr[i]),
            .i_upper  (upper),
            .o_stamp  (msg_stamp[i]),
            .o_in_win (msg_in_win[i])
        );
    end

    // ID tables: table 0 historical requests, table 1 market data lines.
    t_tbl_ctl               tbl_ctl   [2];
    logic [TABLE_DEPTH-1:0] tbl_valid [2];
    logic [TABLE_DEPTH-1:0] tbl_match [2];
    logic [TABLE_DEPTH:0]   tbl_claim [2];
    logic [1:0]             any_match;
    logic [1:0]             any_free;
    logic                   exec_en;

    assign exec_en = (r_state == S_EXEC) && r_enable;

    for (genvar t = 0; t < 2; t++) begin : g_tbl
        logic this_tbl;
        assign this_tbl     = (r_sel == 1'(t));
        assign any_match[t] = |tbl_match[t];
        assign any_free[t]  = tbl_claim[t][TABLE_DEPTH];
        assign tbl_claim[t][0] = 1'b0;

        always_comb begin
            tbl_ctl[t].id          = r_id;
            tbl_ctl[t].now         = r_clock;
            tbl_ctl[t].max_age     = r_max_age;
            tbl_ctl[t].set_new     = exec_en && this_tbl && (r_cmd == CMD_START) &&
                                     !any_match[t];
            tbl_ctl[t].refresh     = exec_en && this_tbl && (r_cmd == CMD_START);
            tbl_ctl[t].clear_match = exec_en && this_tbl && (r_cmd == CMD_END);
            tbl_ctl[t].purge       = exec_en && (r_cmd == CMD_PURGE);
        end

        for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
            swal_tbl_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (tbl_ctl[t]),
                .i_claim (tbl_claim[t][i]),
                .o_claim (tbl_claim[t][i+1]),
                .o_valid (tbl_valid[t][i]),
                .o_match (tbl_match[t][i])
            );
        end
    end

    // Byte-wide count scan over the padded cell vectors.
    logic [NCH*8-1:0] pad_win;
    logic [NCH*8-1:0] pad_hist;
    logic [NCH*8-1:0] pad_line;
    logic [3:0]       pop_win;
    logic [3:0]       pop_hist;
    logic [3:0]       pop_line;
    logic [MCW-1:0]   win_sum;
    logic [TCW-1:0]   hist_sum;
    logic [TCW-1:0]   line_sum;
    logic [MWW-1:0]   win_wide;
    logic [7:0]       win_sat;
    logic             scan_last;

    assign pad_win  = (NCH*8)'(msg_cnt_win);
    assign pad_hist = (NCH*8)'(tbl_valid[0]);
    assign pad_line = (NCH*8)'(tbl_valid[1]);
    assign pop_win  = pop8(pad_win[r_scan*8 +: 8]);
    assign pop_hist = pop8(pad_hist[r_scan*8 +: 8]);
    assign pop_line = pop8(pad_line[r_scan*8 +: 8]);
    assign win_sum  = r_win_acc  + MCW'(pop_win);
    assign hist_sum = r_hist_acc + TCW'(pop_hist);
    assign line_sum = r_line_acc + TCW'(pop_line);
    assign win_wide = MWW'(win_sum);
    assign win_sat  = (win_wide > MWW'(255)) ? 8'd255 : win_wide[7:0];
    assign scan_last = (r_scan == SIW'(NCH - 1));

    // Check-start decision against the counts left by the previous command.
    logic [TCW-1:0] sel_cnt;
    logic [6:0]     sel_limit;
    logic           class_ok;
    logic [MCW-1:0] rec_count;

    assign sel_cnt   = r_sel ? r_line_cnt : r_hist_cnt;
    assign sel_limit = r_sel ? r_max_line : r_max_hist;
    assign class_ok  = (CMPW'(sel_cnt) < CMPW'(sel_limit));
    assign rec_count = ring_full ? r_msg_count : r_msg_count + MCW'(1);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_clock        <= '0;
            r_msg_count    <= '0;
            r_hist_cnt     <= '0;
            r_line_cnt     <= '0;
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd      <= i_command;
                        r_sel      <= i_table_select;
                        r_id       <= i_req_tag;
                        r_elapsed  <= i_elapsed_ticks;
                        r_max_age  <= i_max_age_ticks;
                        r_allowed  <= 1'b0;
                        r_chk_msg  <= 1'b0;
                        r_ovf      <= 1'b0;
                        r_scan     <= '0;
                        r_win_acc  <= '0;
                        r_hist_acc <= '0;
                        r_line_acc <= '0;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_SCAN;
                    case (r_cmd)
                        CMD_TICK: begin
                            r_clock <= r_clock + TS_W'(r_elapsed);
                        end
                        CMD_CHECK_MSG: begin
                            if (r_enable) begin
                                r_chk_msg <= 1'b1;
                                r_state   <= S_EXPIRE;
                            end else begin
                                r_allowed <= 1'b1;
                            end
                        end
                        CMD_RECORD: begin
                            if (r_enable) begin
                                r_msg_count <= rec_count;
                                r_ovf       <= ring_full;
                                if (MWW'(rec_count) > MWW'({r_max_msgs, 1'b0})) begin
                                    r_state <= S_EXPIRE;
                                end
                            end
                        end
                        CMD_CHECK_ST: begin
                            r_allowed <= !r_enable || (!any_match[r_sel] && class_ok);
                        end
                        CMD_START: begin
                            r_ovf <= r_enable && !any_match[r_sel] && !any_free[r_sel];
                        end
                        default: begin
                        end
                    endcase
                end
                S_EXPIRE: begin
                    if (head_expired) begin
                        r_msg_count <= r_msg_count - MCW'(1);
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_win_acc  <= win_sum;
                    r_hist_acc <= hist_sum;
                    r_line_acc <= line_sum;
                    r_scan     <= r_scan + SIW'(1);
                    if (scan_last) begin
                        r_hist_cnt     <= hist_sum;
                        r_line_cnt     <= line_sum;
                        o_result_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result registers, loaded on the last scan cycle.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_SCAN) && scan_last) begin
            o_allowed        <= r_chk_msg ? (win_sat < {2'b00, r_max_msgs}) : r_allowed;
            o_active_hist    <= hist_sum;
            o_active_lines   <= line_sum;
            o_msgs_in_window <= win_sat;
            o_rate_limited   <= (win_sat >= {2'b00, r_max_msgs});
            o_overflow       <= r_ovf;
        end
    end

    // Checks.
    a_done_on_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy fell without a result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while a command is still running");

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_msg_count <= MCW'(MSG_DEPTH))
        else $error("ring fill count beyond its depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

endmodule
